// File: rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Stream marker bytes
  localparam logic [7:0] BOUNDARY_BYTE = 8'h5C;
  localparam logic [7:0] ENDPOINT_BYTE = 8'h10;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned CRC_W  = 16;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
    logic              last_of_frame;
    logic [LEN_W-1:0]  frame_length;
    logic [CRC_W-1:0]  frame_crc;
  } sfd_result_t;

endpackage

// File: rtl/sfd_parser.sv
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state tracker: decodes one registered byte per transfer into the
// next frame section and, where the byte causes one, a result item.
// ----------------------------------------------------------------------------
module sfd_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_vld,
  input  logic [sfd_pkg::BYTE_W-1:0]    byte_in,
  input  logic                          advance,
  output logic                          res_vld,
  output sfd_pkg::sfd_result_t          res
);

  typedef enum logic [2:0] {
    SEC_HUNT = 3'd0,
    SEC_LEN  = 3'd1,
    SEC_CRC1 = 3'd2,
    SEC_CRC2 = 3'd3,
    SEC_DATA = 3'd4
  } section_t;

  section_t                     section_r,   section_nxt;
  logic [sfd_pkg::LEN_W-1:0]    len_r,       len_nxt;
  logic [sfd_pkg::CRC_W-1:0]    crc_r,       crc_nxt;
  logic [sfd_pkg::LEN_W-1:0]    count_r,     count_nxt;
  logic [sfd_pkg::LEN_W-1:0]    count_inc;
  logic [sfd_pkg::CRC_W-1:0]    crc_full;

  assign count_inc = count_r + 1'b1;
  assign crc_full  = {crc_r[sfd_pkg::CRC_W-1:sfd_pkg::BYTE_W], byte_in};

  // Next-state and result decode
  always_comb begin
    section_nxt = section_r;
    len_nxt     = len_r;
    crc_nxt     = crc_r;
    count_nxt   = count_r;
    res_vld     = 1'b0;
    res         = '{data_byte:     '0,
                    has_data:      1'b0,
                    last_of_frame: 1'b0,
                    frame_length:  len_r,
                    frame_crc:     crc_r};
    unique case (section_r)
      SEC_HUNT: begin
        // boundary and stray bytes keep hunting
        if (byte_in == sfd_pkg::ENDPOINT_BYTE) begin
          section_nxt = SEC_LEN;
        end
      end
      SEC_LEN: begin
        len_nxt     = {byte_in, 2'b00};
        section_nxt = SEC_CRC1;
      end
      SEC_CRC1: begin
        crc_nxt     = {byte_in, {sfd_pkg::BYTE_W{1'b0}}};
        section_nxt = SEC_CRC2;
      end
      SEC_CRC2: begin
        crc_nxt   = crc_full;
        count_nxt = '0;
        if (len_r == '0) begin
          // empty frame: one result, then hunt again
          section_nxt       = SEC_HUNT;
          res_vld           = 1'b1;
          res.last_of_frame = 1'b1;
          res.frame_crc     = crc_full;
        end else begin
          section_nxt = SEC_DATA;
        end
      end
      SEC_DATA: begin
        res_vld       = 1'b1;
        res.data_byte = byte_in;
        res.has_data  = 1'b1;
        if (count_inc >= len_r) begin
          res.last_of_frame = 1'b1;
          section_nxt       = SEC_HUNT;
          count_nxt         = '0;
        end else begin
          count_nxt = count_inc;
        end
      end
      default: begin
        section_nxt = SEC_HUNT;
      end
    endcase
  end

  // State registers, updated when the held byte moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r <= SEC_HUNT;
      len_r     <= '0;
      crc_r     <= '0;
      count_r   <= '0;
    end else if (byte_vld && advance) begin
      section_r <= section_nxt;
      len_r     <= len_nxt;
      crc_r     <= crc_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// File: rtl/sfd_out_reg.sv
// ----------------------------------------------------------------------------
// sfd_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module sfd_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  sfd_pkg::sfd_result_t  res_in,
  input  logic                  out_stall,
  output logic                  out_ready,
  output logic                  out_valid,
  output sfd_pkg::sfd_result_t  res_out
);

  logic                  vld_r;
  sfd_pkg::sfd_result_t  res_r;

  // Free when empty or when the held item leaves this cycle
  assign out_ready = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign res_out   = res_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_ready) begin
      vld_r <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_ready && load) begin
      res_r <= res_in;
    end
  end

endmodule

// File: rtl/serial_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer_unit
// Pulls frames out of a received byte stream and emits one result per data
// byte (or one empty result for a zero-length frame), tagged with the
// frame length and the header CRC.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-------------------------------
//   in_     | in  | in_valid / in_stall    | in_rx_byte
//   out_    | out | out_valid / out_stall  | out_data_byte, out_has_data,
//           |     |                        | out_last_of_frame,
//           |     |                        | out_frame_length, out_frame_crc
//
// One byte per cycle sustained while no result is blocked at the output; a
// result passes through the input register, then the result register.
// Reset (rst_n low, synchronous) empties both registers and returns to hunt.
// A stalled result holds the input register only when the held byte makes a
// result; bytes that make none keep flowing behind a stalled output.
// ----------------------------------------------------------------------------
module serial_frame_deframer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfd_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfd_pkg::BYTE_W-1:0]    out_data_byte,
  output logic                          out_has_data,
  output logic                          out_last_of_frame,
  output logic [sfd_pkg::LEN_W-1:0]     out_frame_length,
  output logic [sfd_pkg::CRC_W-1:0]     out_frame_crc
);

  logic                          s1_vld_r;
  logic [sfd_pkg::BYTE_W-1:0]    s1_byte_r;
  logic                          advance;
  logic                          out_ready;
  logic                          res_vld;
  logic                          in_accept;
  sfd_pkg::sfd_result_t          res;
  sfd_pkg::sfd_result_t          res_q;

  // Held byte moves on unless its result is blocked
  assign advance   = s1_vld_r && (!res_vld || out_ready);
  assign in_stall  = s1_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_accept) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  sfd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (s1_vld_r),
    .byte_in  (s1_byte_r),
    .advance  (advance),
    .res_vld  (res_vld),
    .res      (res)
  );

  sfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_vld),
    .res_in    (res),
    .out_stall (out_stall),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign out_data_byte     = res_q.data_byte;
  assign out_has_data      = res_q.has_data;
  assign out_last_of_frame = res_q.last_of_frame;
  assign out_frame_length  = res_q.frame_length;
  assign out_frame_crc     = res_q.frame_crc;

  // Stall toward the source only comes from a held byte
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("in_stall raised with empty input register");

  // A blocked byte stays put
  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !advance) |=> (s1_vld_r && $stable(s1_byte_r)))
    else $error("blocked input byte lost or changed");

  // Empty results only close a zero-length frame
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_data) |->
      (out_last_of_frame && out_frame_length == '0 && out_data_byte == '0))
    else $error("malformed empty-frame result");

  // Frame length is always a whole number of words
  a_len_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_length[1:0] == 2'b00))
    else $error("frame length not a multiple of four");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for serial_frame_deframer_unit. A byte stream of hunt noise,
// zero-length frames, short frames and a maximum-length header at the tail is
// pushed through the input channel with random gaps. A local deframer follows
// each accepted byte and queues the payload results it must produce. Results
// leaving the block under random stall are checked field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned RANDOM_BYTES = 420;
  localparam int unsigned LONG_TAIL_BYTES = 40;

  // Deframer sections
  typedef enum logic [2:0] {
    SEC_HUNT,
    SEC_LEN,
    SEC_CRC_HI,
    SEC_CRC_LO,
    SEC_DATA
  } section_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [sfd_pkg::BYTE_W-1:0] in_rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [sfd_pkg::BYTE_W-1:0] out_data_byte;
  logic out_has_data;
  logic out_last_of_frame;
  logic [sfd_pkg::LEN_W-1:0] out_frame_length;
  logic [sfd_pkg::CRC_W-1:0] out_frame_crc;

  // Bytes waiting to go onto the line, and payload results still owed
  logic [7:0] line_q[$];
  sfd_pkg::sfd_result_t payload_q[$];

  // Local deframer state
  section_t sect = SEC_HUNT;
  logic [sfd_pkg::LEN_W-1:0] len_bytes = '0;
  logic [sfd_pkg::CRC_W-1:0] hdr_crc = '0;
  logic [sfd_pkg::LEN_W-1:0] data_cnt = '0;

  int unsigned error_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  logic calm;

  // No idling on either side through the middle of the stream
  assign calm = (bytes_sent >= 150) && (bytes_sent < 300);

  serial_frame_deframer_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_byte    (out_data_byte),
    .out_has_data     (out_has_data),
    .out_last_of_frame(out_last_of_frame),
    .out_frame_length (out_frame_length),
    .out_frame_crc    (out_frame_crc)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  function automatic sfd_pkg::sfd_result_t tag_result(input logic [7:0] data,
                                                       input logic has,
                                                       input logic last);
    sfd_pkg::sfd_result_t r;
    r.data_byte     = data;
    r.has_data      = has;
    r.last_of_frame = last;
    r.frame_length  = len_bytes;
    r.frame_crc     = hdr_crc;
    return r;
  endfunction

  // Advance the local deframer by one received byte
  task automatic deframe_byte(input logic [7:0] c);
    case (sect)
      SEC_HUNT: begin
        // boundary and stray bytes are dropped; only the endpoint opens a frame
        if (c == sfd_pkg::ENDPOINT_BYTE) sect = SEC_LEN;
      end
      SEC_LEN: begin
        len_bytes = {c, 2'b00};
        sect = SEC_CRC_HI;
      end
      SEC_CRC_HI: begin
        hdr_crc = {c, 8'h00};
        sect = SEC_CRC_LO;
      end
      SEC_CRC_LO: begin
        hdr_crc[7:0] = c;
        data_cnt = '0;
        if (len_bytes == '0) begin
          // empty frame closes at once
          payload_q.push_back(tag_result(8'h00, 1'b0, 1'b1));
          sect = SEC_HUNT;
        end else begin
          sect = SEC_DATA;
        end
      end
      SEC_DATA: begin
        data_cnt = data_cnt + 1'b1;
        if (data_cnt >= len_bytes) begin
          payload_q.push_back(tag_result(c, 1'b1, 1'b1));
          sect = SEC_HUNT;
          data_cnt = '0;
        end else begin
          payload_q.push_back(tag_result(c, 1'b1, 1'b0));
        end
      end
      default: sect = SEC_HUNT;
    endcase
  endtask

  // Data bytes lean on the marker values, which must pass as plain data
  function automatic logic [7:0] pick_data();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return sfd_pkg::BOUNDARY_BYTE;
    if (roll < 15) return sfd_pkg::ENDPOINT_BYTE;
    return 8'($urandom);
  endfunction

  task automatic send_header(input logic [7:0] words, input logic [15:0] crc);
    line_q.push_back(sfd_pkg::ENDPOINT_BYTE);
    line_q.push_back(words);
    line_q.push_back(crc[15:8]);
    line_q.push_back(crc[7:0]);
  endtask

  task automatic send_frame(input logic [7:0] words, input logic [15:0] crc);
    send_header(words, crc);
    for (int i = 0; i < 4 * words; i++) line_q.push_back(pick_data());
  endtask

  task automatic build_stream();
    int unsigned framed;
    logic [7:0] words;
    framed = 0;
    // hunt noise: boundary bytes and strays, both extremes
    line_q.push_back(sfd_pkg::BOUNDARY_BYTE);
    line_q.push_back(sfd_pkg::BOUNDARY_BYTE);
    line_q.push_back(8'hA7);
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    // empty frame, then a frame straight after it must not lose its endpoint
    send_header(8'h00, 16'hFFFF);
    send_header(8'h01, 16'h0000);
    line_q.push_back(sfd_pkg::BOUNDARY_BYTE);
    line_q.push_back(sfd_pkg::ENDPOINT_BYTE);
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    send_header(8'h00, 16'h0000);

    // random frames with noise in between
    while (framed < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) line_q.push_back(sfd_pkg::BOUNDARY_BYTE);
          else line_q.push_back(8'($urandom));
        end
      end
      words = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
      send_frame(words, 16'($urandom));
      framed += 4 + 4 * words;
    end

    // longest length byte, cut short by the end of the stream
    send_header(8'hFF, 16'h8001);
    repeat (LONG_TAIL_BYTES) line_q.push_back(pick_data());
  endtask

  // Input driver: hold a stalled byte, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_rx_byte);
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (line_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          in_valid <= 1'b1;
          in_rx_byte <= line_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest owed result
  always @(posedge clk) begin
    sfd_pkg::sfd_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (payload_q.size() == 0) begin
          report_mismatch("unexpected result, data_byte", 32'(out_data_byte), 0);
        end else begin
          want = payload_q.pop_front();
          if (out_data_byte !== want.data_byte)
            report_mismatch("data_byte", 32'(out_data_byte), 32'(want.data_byte));
          if (out_has_data !== want.has_data)
            report_mismatch("has_data", 32'(out_has_data), 32'(want.has_data));
          if (out_last_of_frame !== want.last_of_frame)
            report_mismatch("last_of_frame", 32'(out_last_of_frame),
                            32'(want.last_of_frame));
          if (out_frame_length !== want.frame_length)
            report_mismatch("frame_length", 32'(out_frame_length),
                            32'(want.frame_length));
          if (out_frame_crc !== want.frame_crc)
            report_mismatch("frame_crc", 32'(out_frame_crc), 32'(want.frame_crc));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 10);
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("serial_frame_deframer_unit regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    build_stream();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // sample at the falling edge, clear of the driver's updates
    @(negedge clk);
    while (line_q.size() != 0 || in_valid || payload_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("serial_frame_deframer_unit regression: pass");
    end else begin
      $display("serial_frame_deframer_unit regression: fail");
    end
    $finish;
  end

endmodule
